// ----- rtl/evhp_pkg.sv -----
// Shared types and constants of the Ethernet/VLAN/IPv4/L4 header parser.
`timescale 1ns / 1ps

package evhp_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int unsigned ETH_HDR_BYTES   = 14;
    localparam int unsigned ETH_TYPE_OFS    = 12;
    localparam int unsigned IP_MIN_BYTES    = 20;
    localparam int unsigned IP_FRAG_OFS     = 6;
    localparam int unsigned IP_PROTO_OFS    = 9;
    localparam int unsigned TCP_FLAGS_OFS   = 13;
    localparam int unsigned CTAG_BYTES      = 4;
    localparam int unsigned STAG_BYTES      = 8;

    localparam logic [15:0] TYPE_IPV4       = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [7:0]  TCP_FIN_RST     = 8'h05;

    localparam logic [15:0] CVLAN_RESET     = 16'h8100;
    localparam logic [15:0] SVLAN_RESET     = 16'h88A8;

    localparam int unsigned CFG_IDX_W       = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CVLAN_TPID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SVLAN_TPID = CFG_IDX_W'(1);

    localparam int unsigned QDEPTH          = 4;
    localparam int unsigned QPTR_W          = $clog2(QDEPTH);
    localparam int unsigned QCNT_W          = $clog2(QDEPTH + 1);

    localparam int unsigned IN_TDATA_W      = 8;
    localparam int unsigned OUT_TDATA_W     = 32;

    typedef enum logic [2:0] {
        K_NONE,
        K_TYPE_HI,
        K_TYPE_LO,
        K_IHL,
        K_FRAG_HI,
        K_FRAG_LO,
        K_PROTO,
        K_FLAGS
    } byte_kind_t;

    typedef enum logic [1:0] {
        ST_PARSED      = 2'd0,
        ST_INCOMPLETE  = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        byte_kind_t kind;
        logic       tag_short;
        logic       ip_short;
        logic [3:0] skip;
        logic [5:0] ihl;
    } entry_t;

    typedef struct packed {
        logic [6:0] l4_offset;
        logic [4:0] l3_offset;
        logic [3:0] tag_bytes;
        logic       flags_captured;
        logic       fin_or_reset;
        logic [7:0] tcp_flag_bits;
        logic       is_udp;
        logic       is_tcp;
        status_t    status;
    } result_t;

endpackage

// ----- rtl/evhp_front.sv -----
// Front end: byte counting, tag and header position tracking, byte classification.
`timescale 1ns / 1ps

module evhp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [evhp_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic [15:0]                    cvlan_tpid,
    input  logic [15:0]                    svlan_tpid,
    input  logic                           q_full,
    output logic                           q_push,
    output evhp_pkg::entry_t               q_entry
);
    import evhp_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       hi_reg, hi_next;
    logic [3:0]       skip_reg, skip_next;
    logic [5:0]       ihl_reg, ihl_next;

    logic [7:0]       data;
    logic             take;
    logic [CNT_W-1:0] l3_cur;
    logic [CNT_W-1:0] l3_new;
    byte_kind_t       kind;

    assign data     = s_tdata[7:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        take      = (cnt_reg != CNT_W'(MAX_FRAME_BYTES));
        l3_cur    = CNT_W'(ETH_HDR_BYTES) + CNT_W'(skip_reg);
        kind      = K_NONE;
        hi_next   = hi_reg;
        skip_next = skip_reg;
        ihl_next  = ihl_reg;
        cnt_next  = take ? cnt_reg + 1'b1 : cnt_reg;

        if (take) begin
            if (cnt_reg == CNT_W'(ETH_TYPE_OFS)) begin
                kind    = K_TYPE_HI;
                hi_next = data;
            end
            if (cnt_reg == CNT_W'(ETH_TYPE_OFS + 1)) begin
                kind = K_TYPE_LO;
                if ({hi_reg, data} == svlan_tpid) begin
                    skip_next = 4'(STAG_BYTES);
                end else if ({hi_reg, data} == cvlan_tpid) begin
                    skip_next = 4'(CTAG_BYTES);
                end else begin
                    skip_next = '0;
                end
            end else begin
                if (skip_reg != '0 && cnt_reg == CNT_W'(ETH_TYPE_OFS) + CNT_W'(skip_reg)) begin
                    kind = K_TYPE_HI;
                end
                if (skip_reg != '0
                    && cnt_reg == CNT_W'(ETH_TYPE_OFS + 1) + CNT_W'(skip_reg)) begin
                    kind = K_TYPE_LO;
                end
                if (cnt_reg >= CNT_W'(ETH_HDR_BYTES)) begin
                    if (cnt_reg == l3_cur) begin
                        kind     = K_IHL;
                        ihl_next = {data[3:0], 2'b00};
                    end
                    if (cnt_reg == l3_cur + CNT_W'(IP_FRAG_OFS)) begin
                        kind = K_FRAG_HI;
                    end
                    if (cnt_reg == l3_cur + CNT_W'(IP_FRAG_OFS + 1)) begin
                        kind = K_FRAG_LO;
                    end
                    if (cnt_reg == l3_cur + CNT_W'(IP_PROTO_OFS)) begin
                        kind = K_PROTO;
                    end
                    if (cnt_reg > l3_cur
                        && cnt_reg == l3_cur + CNT_W'(ihl_reg) + CNT_W'(TCP_FLAGS_OFS)) begin
                        kind = K_FLAGS;
                    end
                end
            end
        end

        l3_new = CNT_W'(ETH_HDR_BYTES) + CNT_W'(skip_next);

        q_entry.data      = data;
        q_entry.last      = s_tlast;
        q_entry.kind      = kind;
        q_entry.skip      = skip_next;
        q_entry.ihl       = ihl_next;
        q_entry.tag_short = (cnt_next < l3_new);
        q_entry.ip_short  = (cnt_next < l3_new + CNT_W'(IP_MIN_BYTES))
                            || (ihl_next > 6'(IP_MIN_BYTES)
                                && cnt_next < l3_new + CNT_W'(ihl_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            hi_reg   <= '0;
            skip_reg <= '0;
            ihl_reg  <= '0;
        end else if (q_push) begin
            if (s_tlast) begin
                cnt_reg  <= '0;
                hi_reg   <= '0;
                skip_reg <= '0;
                ihl_reg  <= '0;
            end else begin
                cnt_reg  <= cnt_next;
                hi_reg   <= hi_next;
                skip_reg <= skip_next;
                ihl_reg  <= ihl_next;
            end
        end
    end

endmodule

// ----- rtl/evhp_queue.sv -----
// Short queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps

module evhp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  evhp_pkg::entry_t push_entry,
    input  logic             pop,
    output evhp_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import evhp_pkg::*;

    entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("Queue popped while empty.");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> !full)
        else $error("Queue pushed while full.");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a push.");
`endif

endmodule

// ----- rtl/evhp_back.sv -----
// Back end: header field capture, frame verdict and the result output register.
`timescale 1ns / 1ps

module evhp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  evhp_pkg::entry_t  head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output evhp_pkg::result_t m_result
);
    import evhp_pkg::*;

    logic [15:0] type_reg, type_next;
    logic [12:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [7:0]  flags_reg, flags_next;
    logic        seen_reg, seen_next;
    logic        m_valid_reg;
    result_t     result_reg;
    result_t     verdict;
    logic        out_free;
    logic [4:0]  l3;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = !q_empty && (!head.last || out_free);
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    always_comb begin
        type_next  = type_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        flags_next = flags_reg;
        seen_next  = seen_reg;
        case (head.kind)
            K_TYPE_HI: type_next  = {head.data, 8'h00};
            K_TYPE_LO: type_next  = {type_reg[15:8], head.data};
            K_FRAG_HI: frag_next  = {head.data[4:0], 8'h00};
            K_FRAG_LO: frag_next  = {frag_reg[12:8], head.data};
            K_PROTO:   proto_next = head.data;
            K_FLAGS: begin
                flags_next = head.data;
                seen_next  = 1'b1;
            end
            default: ;
        endcase

        l3      = 5'(ETH_HDR_BYTES) + 5'(head.skip);
        verdict = '0;
        if (head.tag_short) begin
            verdict.status = ST_INCOMPLETE;
        end else if (type_next != TYPE_IPV4) begin
            verdict.status = ST_UNSUPPORTED;
        end else if (head.ip_short) begin
            verdict.status = ST_INCOMPLETE;
        end else if (frag_next != '0) begin
            verdict.status = ST_UNSUPPORTED;
        end else if (proto_next == PROTO_TCP || proto_next == PROTO_UDP) begin
            verdict.status    = ST_PARSED;
            verdict.is_tcp    = (proto_next == PROTO_TCP);
            verdict.is_udp    = (proto_next == PROTO_UDP);
            verdict.tag_bytes = head.skip;
            verdict.l3_offset = l3;
            verdict.l4_offset = 7'(l3) + 7'(head.ihl);
            if (proto_next == PROTO_TCP && seen_next) begin
                verdict.flags_captured = 1'b1;
                verdict.tcp_flag_bits  = flags_next;
                verdict.fin_or_reset   = (flags_next & TCP_FIN_RST) != '0;
            end
        end else begin
            verdict.status = ST_UNSUPPORTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_reg    <= '0;
            frag_reg    <= '0;
            proto_reg   <= '0;
            flags_reg   <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                if (head.last) begin
                    type_reg  <= '0;
                    frag_reg  <= '0;
                    proto_reg <= '0;
                    flags_reg <= '0;
                    seen_reg  <= 1'b0;
                end else begin
                    type_reg  <= type_next;
                    frag_reg  <= frag_next;
                    proto_reg <= proto_next;
                    flags_reg <= flags_next;
                    seen_reg  <= seen_next;
                end
            end
            if (q_pop && head.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head.last) begin
            result_reg <= verdict;
        end
    end

endmodule

// ----- rtl/eth_vlan_ipv4_l4_header_parser.sv -----
// Top level of the Ethernet/VLAN/IPv4/L4 header parser with its configuration registers.
`timescale 1ns / 1ps

// The parser takes one frame byte per cycle on the slave stream, with tlast on the final
// captured byte, and returns one result word per frame on the master stream. The front end
// classifies each byte and writes it into a four-word queue; the back end captures header
// fields and registers the verdict once the last byte leaves the queue. Input is stalled
// only when the queue is full, i.e. only while a finished result is held by a stalled
// master side. The user must write the two tag type values through the configuration
// channel only while idle, which the block does not enforce; other indexes are ignored.
module eth_vlan_ipv4_l4_header_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: data_byte[7:0]
    input  logic [evhp_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: status[1:0], is_tcp[2], is_udp[3], tcp_flag_bits[11:4], fin_or_reset[12],
    // flags_captured[13], tag_bytes[17:14], l3_offset[22:18], l4_offset[29:23], zero[31:30]
    output logic [evhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [evhp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                         cfg_data
);
    import evhp_pkg::*;

    logic [15:0] cvlan_tpid_reg;
    logic [15:0] svlan_tpid_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    entry_t      q_in;
    entry_t      q_head;
    result_t     result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvlan_tpid_reg <= CVLAN_RESET;
            svlan_tpid_reg <= SVLAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_CVLAN_TPID) begin
                cvlan_tpid_reg <= cfg_data;
            end else if (cfg_index == CFG_SVLAN_TPID) begin
                svlan_tpid_reg <= cfg_data;
            end
        end
    end

    evhp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cvlan_tpid (cvlan_tpid_reg),
        .svlan_tpid (svlan_tpid_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    evhp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    evhp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {2'b00, result.l4_offset, result.l3_offset, result.tag_bytes,
                      result.flags_captured, result.fin_or_reset, result.tcp_flag_bits,
                      result.is_udp, result.is_tcp, result.status};

endmodule

// ----- bench/evhp_checker.sv -----
// Scoreboard for the header parser: predicts one result word per frame and checks each result.
`timescale 1ns / 1ps

module evhp_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [evhp_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [evhp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [evhp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 n_parsed,
    output int                                 n_incomplete,
    output int                                 n_unsupported
);

    import evhp_pkg::*;

    localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
    localparam int unsigned RES_W         = $bits(result_t);

    logic [15:0] cvlan_type;
    logic [15:0] svlan_type;

    int unsigned byte_pos;
    logic [15:0] type_acc;
    logic [3:0]  tag_skip;
    logic [6:0]  ip_hlen;
    logic [15:0] frag_acc;
    logic [7:0]  proto_acc;
    logic [7:0]  tflags_acc;
    logic        tflags_seen;

    result_t     verdict_q[$];
    result_t     verdict;
    result_t     want;
    result_t     got;

    task automatic new_frame();
        byte_pos    = 0;
        type_acc    = '0;
        tag_skip    = '0;
        ip_hlen     = '0;
        frag_acc    = '0;
        proto_acc   = '0;
        tflags_acc  = '0;
        tflags_seen = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int unsigned l3;
        l3 = ETH_HDR_BYTES + tag_skip;
        if (byte_pos == ETH_TYPE_OFS) type_acc = {b, 8'h00};
        if (byte_pos == ETH_TYPE_OFS + 1) begin
            type_acc[7:0] = b;
            if (type_acc == svlan_type) tag_skip = 4'(STAG_BYTES);
            else if (type_acc == cvlan_type) tag_skip = 4'(CTAG_BYTES);
            else tag_skip = '0;
        end else begin
            if (tag_skip != 0 && byte_pos == ETH_TYPE_OFS + tag_skip) type_acc = {b, 8'h00};
            if (tag_skip != 0 && byte_pos == ETH_TYPE_OFS + 1 + tag_skip) type_acc[7:0] = b;
            if (byte_pos >= ETH_HDR_BYTES) begin
                if (byte_pos == l3) ip_hlen = {1'b0, b[3:0], 2'b00};
                if (byte_pos == l3 + IP_FRAG_OFS) frag_acc = {b, 8'h00};
                if (byte_pos == l3 + IP_FRAG_OFS + 1) frag_acc[7:0] = b;
                if (byte_pos == l3 + IP_PROTO_OFS) proto_acc = b;
                if (byte_pos > l3 && byte_pos == l3 + ip_hlen + TCP_FLAGS_OFS) begin
                    tflags_acc  = b;
                    tflags_seen = 1'b1;
                end
            end
        end
    endtask

    function automatic result_t frame_verdict();
        result_t     r;
        int unsigned l3;
        int unsigned avail;
        status_t     st;
        r     = '0;
        l3    = ETH_HDR_BYTES + tag_skip;
        avail = byte_pos - l3;
        if (byte_pos < ETH_HDR_BYTES || byte_pos < l3) st = ST_INCOMPLETE;
        else if (type_acc != TYPE_IPV4) st = ST_UNSUPPORTED;
        else if (avail < IP_MIN_BYTES || (ip_hlen > IP_MIN_BYTES && avail < ip_hlen))
            st = ST_INCOMPLETE;
        else if ((frag_acc & FRAG_OFS_MASK) != '0) st = ST_UNSUPPORTED;
        else if (proto_acc == PROTO_TCP || proto_acc == PROTO_UDP) st = ST_PARSED;
        else st = ST_UNSUPPORTED;
        r.status = st;
        if (st == ST_PARSED) begin
            r.is_tcp = (proto_acc == PROTO_TCP);
            r.is_udp = (proto_acc == PROTO_UDP);
            if (r.is_tcp && tflags_seen) begin
                r.flags_captured = 1'b1;
                r.tcp_flag_bits  = tflags_acc;
                r.fin_or_reset   = |(tflags_acc & TCP_FIN_RST);
            end
            r.tag_bytes = tag_skip;
            r.l3_offset = 5'(l3);
            r.l4_offset = 7'(l3 + ip_hlen);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cvlan_type    = CVLAN_RESET;
            svlan_type    = SVLAN_RESET;
            new_frame();
            verdict_q.delete();
            fail_count    = 0;
            pending       = 0;
            n_parsed      = 0;
            n_incomplete  = 0;
            n_unsupported = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CVLAN_TPID) cvlan_type = cfg_data;
                else if (cfg_index == CFG_SVLAN_TPID) svlan_type = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                // Bytes past the largest frame are dropped and the length saturates.
                if (byte_pos < MAX_FRAME_BYTES) begin
                    absorb_byte(s_tdata);
                    byte_pos++;
                end
                if (s_tlast) begin
                    verdict = frame_verdict();
                    verdict_q.push_back(verdict);
                    pending++;
                    if (verdict.status == ST_PARSED) n_parsed++;
                    else if (verdict.status == ST_INCOMPLETE) n_incomplete++;
                    else n_unsupported++;
                    new_frame();
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending == 0) begin
                    $error("result word 0x%08h with no frame outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    pending--;
                    got  = m_tdata[RES_W-1:0];
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("is_tcp", 32'(want.is_tcp), 32'(got.is_tcp));
                    check_field("is_udp", 32'(want.is_udp), 32'(got.is_udp));
                    check_field("tcp_flag_bits", 32'(want.tcp_flag_bits),
                                32'(got.tcp_flag_bits));
                    check_field("fin_or_reset", 32'(want.fin_or_reset),
                                32'(got.fin_or_reset));
                    check_field("flags_captured", 32'(want.flags_captured),
                                32'(got.flags_captured));
                    check_field("tag_bytes", 32'(want.tag_bytes), 32'(got.tag_bytes));
                    check_field("l3_offset", 32'(want.l3_offset), 32'(got.l3_offset));
                    check_field("l4_offset", 32'(want.l4_offset), 32'(got.l4_offset));
                    check_field("padding", 0, 32'(m_tdata[OUT_TDATA_W-1:RES_W]));
                end
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the header parser testbench: clock, reset, frame stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;

    import evhp_pkg::*;

    typedef enum int {TAG_NONE, TAG_C, TAG_S} tag_kind_t;

    localparam int          CYCLE_LIMIT      = 2000000;
    localparam int          SETTLE_CYCLES    = 16;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  IHL_NONE         = 4'd0;
    localparam logic [3:0]  IHL_SHORT        = 4'd3;
    localparam logic [3:0]  IHL_PLAIN        = 4'd5;
    localparam logic [3:0]  IHL_MAX          = 4'd15;
    localparam logic [15:0] TYPE_LEN_MAX     = 16'd1500;
    localparam logic [15:0] TYPE_IPV6        = 16'h86DD;
    localparam logic [15:0] TYPE_ALL_ONES    = 16'hFFFF;
    localparam logic [15:0] FRAG_NONE        = 16'h0000;
    localparam logic [15:0] FRAG_OFS_MAX     = 16'h1FFF;
    localparam logic [15:0] FRAG_FLAGS_ONLY  = 16'hE000;
    localparam logic [7:0]  PROTO_ZERO       = 8'd0;
    localparam logic [7:0]  PROTO_RAW        = 8'd255;
    localparam logic [7:0]  TCP_NO_FLAGS     = 8'h00;
    localparam logic [7:0]  TCP_FIN          = 8'h01;
    localparam logic [7:0]  TCP_RST          = 8'h04;
    localparam logic [7:0]  TCP_OTHER_FLAGS  = 8'hFA;
    localparam logic [7:0]  TCP_ALL_FLAGS    = 8'hFF;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [15:0]             cfg_data;

    int fail_count;
    int pending;
    int n_parsed;
    int n_incomplete;
    int n_unsupported;

    int          cycle_count;
    int          bytes_sent;
    int          frames_sent;
    bit          src_gaps;
    bit          sink_stalls;
    logic [15:0] cur_cvlan;
    logic [15:0] cur_svlan;
    logic [7:0]  frame_q[$];

    eth_vlan_ipv4_l4_header_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    evhp_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_parsed      (n_parsed),
        .n_incomplete  (n_incomplete),
        .n_unsupported (n_unsupported)
    );

    always #6 aclk = ~aclk;

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // The result side stalls in random bursts while stalls are enabled.
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
        bytes_sent += frame_q.size();
        frames_sent++;
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == CFG_CVLAN_TPID) cur_cvlan = val;
        else if (idx == CFG_SVLAN_TPID) cur_svlan = val;
    endtask

    task automatic put8(input int pos, input logic [7:0] v);
        if (pos < frame_q.size()) frame_q[pos] = v;
    endtask

    task automatic put16(input int pos, input logic [15:0] v);
        put8(pos, v[15:8]);
        put8(pos + 1, v[7:0]);
    endtask

    // Random filler with the header fields of interest written over it; a length of
    // zero means the whole header up to the TCP flags plus zero to six random bytes.
    task automatic make_frame(input tag_kind_t tag, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [15:0] frag,
                              input logic [7:0] proto, input logic [7:0] tflags,
                              input int len);
        int l3;
        int fpos;
        int n;
        int i;
        l3   = ETH_HDR_BYTES + (tag == TAG_S ? STAG_BYTES : tag == TAG_C ? CTAG_BYTES : 0);
        fpos = l3 + 4 * ihl + TCP_FLAGS_OFS;
        n    = (len > 0) ? len : fpos + 1 + $urandom_range(0, 6);
        frame_q.delete();
        for (i = 0; i < n; i++) frame_q.push_back(8'($urandom));
        put16(ETH_TYPE_OFS, tag == TAG_S ? cur_svlan : tag == TAG_C ? cur_cvlan : etype);
        if (tag == TAG_C) put16(ETH_TYPE_OFS + CTAG_BYTES, etype);
        if (tag == TAG_S) begin
            put16(ETH_TYPE_OFS + CTAG_BYTES, cur_cvlan);
            put16(ETH_TYPE_OFS + STAG_BYTES, etype);
        end
        put8(l3, {($urandom_range(0, 3) == 0) ? 4'($urandom) : IP_VERSION, ihl});
        put16(l3 + IP_FRAG_OFS, frag);
        put8(l3 + IP_PROTO_OFS, proto);
        put8(fpos, tflags);
    endtask

    task automatic test_frame(input tag_kind_t tag, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [15:0] frag,
                              input logic [7:0] proto, input logic [7:0] tflags,
                              input int len);
        make_frame(tag, etype, ihl, frag, proto, tflags, len);
        send_frame();
    endtask

    task automatic uniform_frame(input logic [7:0] v, input int len);
        int i;
        frame_q.delete();
        for (i = 0; i < len; i++) frame_q.push_back(v);
        send_frame();
    endtask

    task automatic rand_frame();
        int          pick;
        tag_kind_t   tag;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [15:0] frag;
        logic [7:0]  proto;
        int          cut;
        pick  = $urandom_range(0, 9);
        tag   = (pick < 5) ? TAG_NONE : (pick < 8) ? TAG_C : TAG_S;
        etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : TYPE_IPV4;
        ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : IHL_PLAIN;
        frag  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : {3'($urandom), 13'h0};
        pick  = $urandom_range(0, 19);
        proto = (pick < 9) ? PROTO_TCP : (pick < 17) ? PROTO_UDP : 8'($urandom);
        make_frame(tag, etype, ihl, frag, proto, 8'($urandom), 0);
        if ($urandom_range(0, 2) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
        send_frame();
    endtask

    task automatic random_phase(input int byte_goal, input int frame_goal, input bit gaps);
        int b0;
        int f0;
        b0 = bytes_sent;
        f0 = frames_sent;
        while (bytes_sent - b0 < byte_goal || frames_sent - f0 < frame_goal) begin
            // Without gaps all frames go out back to back; with gaps, some do and the rest get random holes.
            src_gaps = gaps && $urandom_range(0, 3) != 0;
            rand_frame();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        bytes_sent  = 0;
        frames_sent = 0;
        cur_cvlan   = CVLAN_RESET;
        cur_svlan   = SVLAN_RESET;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames with the tag types at their reset values.
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN, 1);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN,
                   ETH_HDR_BYTES - 1);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN,
                   ETH_HDR_BYTES);
        test_frame(TAG_NONE, TYPE_LEN_MAX, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN, 0);
        test_frame(TAG_C, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_UDP, TCP_FIN,
                   ETH_HDR_BYTES + CTAG_BYTES - 1);
        test_frame(TAG_S, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_UDP, TCP_FIN,
                   ETH_HDR_BYTES + STAG_BYTES - 1);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_UDP, TCP_NO_FLAGS,
                   ETH_HDR_BYTES + IP_MIN_BYTES);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN, 0);
        test_frame(TAG_C, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_RST, 0);
        test_frame(TAG_S, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_OTHER_FLAGS, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN,
                   ETH_HDR_BYTES + IP_MIN_BYTES + TCP_FLAGS_OFS);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_RST,
                   ETH_HDR_BYTES + IP_MIN_BYTES + TCP_FLAGS_OFS + 1);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_MAX, FRAG_NONE, PROTO_TCP, TCP_FIN,
                   ETH_HDR_BYTES + 4 * IHL_MAX - 1);
        test_frame(TAG_S, TYPE_IPV4, IHL_MAX, FRAG_NONE, PROTO_TCP, TCP_ALL_FLAGS, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_NONE, FRAG_NONE, PROTO_TCP, TCP_RST, 0);
        test_frame(TAG_C, TYPE_IPV4, IHL_SHORT, FRAG_NONE, PROTO_UDP, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_OFS_MAX, PROTO_TCP, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_FLAGS_ONLY, PROTO_UDP, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_RAW, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_ZERO, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_IPV4, IHL_PLAIN, FRAG_NONE, PROTO_UDP, TCP_FIN,
                   ETH_HDR_BYTES + IP_MIN_BYTES - 1);
        test_frame(TAG_C, TYPE_IPV6, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN, 0);
        test_frame(TAG_NONE, TYPE_ALL_ONES, IHL_PLAIN, FRAG_NONE, PROTO_TCP, TCP_FIN, 0);
        uniform_frame(8'hFF, 32);
        uniform_frame(8'h00, 32);

        write_reg(CFG_CVLAN_TPID, 16'h9100);
        write_reg(CFG_SVLAN_TPID, SVLAN_RESET);
        random_phase(30, 1, 1'b1);
        // Let every outstanding result come out before more bytes go in.
        wait_drain();
        random_phase(30, 1, 1'b1);

        write_reg(CFG_CVLAN_TPID, 16'h0000);
        write_reg(CFG_SVLAN_TPID, 16'hFFFF);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SVLAN_TPID + 1, (1 << CFG_IDX_W) - 1)),
                  16'($urandom));
        random_phase(30, 1, 1'b1);

        write_reg(CFG_CVLAN_TPID, 16'hFFFF);
        write_reg(CFG_SVLAN_TPID, 16'h0000);
        random_phase(30, 1, 1'b1);

        // Equal tag types: the service tag takes precedence.
        write_reg(CFG_CVLAN_TPID, 16'($urandom));
        write_reg(CFG_SVLAN_TPID, cur_cvlan);
        random_phase(30, 1, 1'b1);

        // The IPv4 type itself taken as a customer tag.
        write_reg(CFG_CVLAN_TPID, TYPE_IPV4);
        write_reg(CFG_SVLAN_TPID, 16'($urandom));
        random_phase(30, 1, 1'b1);

        write_reg(CFG_CVLAN_TPID, CVLAN_RESET);
        write_reg(CFG_SVLAN_TPID, SVLAN_RESET);
        sink_stalls = 1'b0;
        random_phase(30, 1, 1'b0);

        wait_drain();
        $display("Sent %0d bytes in %0d frames over seven tag type settings.",
                 bytes_sent, frames_sent);
        $display("Results: %0d parsed, %0d incomplete, %0d unsupported.",
                 n_parsed, n_incomplete, n_unsupported);
        if (fail_count == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

endmodule
